### hw/rtl/csd_pkg.sv
package csd_pkg;

	localparam int BufferBytes = 256;
	localparam int HdrBytes    = 16;
	localparam int AddrW       = $clog2(BufferBytes);
	localparam int VarW        = 62;
	localparam int HcW         = 5;
	localparam int VblW        = 3;

	typedef logic [VarW-1:0] var_t;

	typedef enum logic [1:0] {
		PhType = 2'd0,
		PhLen  = 2'd1,
		PhPay  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		StMore = 2'd0,
		StDone = 2'd1,
		StErr  = 2'd2,
		StRead = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KindHdr = 2'd0,
		KindPay = 2'd1,
		KindRej = 2'd2
	} kind_t;

	localparam var_t WtCloseSession       = 62'h2843;
	localparam var_t WtDrainSession       = 62'h78AE;
	localparam var_t WtMaxData            = 62'h190B4D3D;
	localparam var_t WtMaxStreamsBidi     = 62'h190B4D3F;
	localparam var_t WtMaxStreamsUni      = 62'h190B4D40;
	localparam var_t WtDataBlocked        = 62'h190B4D41;
	localparam var_t WtStreamsBlockedBidi = 62'h190B4D43;
	localparam var_t WtStreamsBlockedUni  = 62'h190B4D44;

	localparam var_t BufTypes [8] = '{
		WtCloseSession, WtDrainSession, WtMaxData, WtMaxStreamsBidi,
		WtMaxStreamsUni, WtDataBlocked, WtStreamsBlockedBidi, WtStreamsBlockedUni
	};

	function automatic logic is_buffered(var_t t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (BufTypes[i] == t) hit = 1'b1;
		end
		return hit;
	endfunction

	typedef struct packed {
		status_t     status;
		kind_t       kind;
		var_t        ctype;
		var_t        plen;
		logic        streamed;
		logic [7:0]  pbyte;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [AddrW-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

endpackage

### hw/rtl/csd_store.sv
module csd_store (
	input  logic                      clk,
	input  csd_pkg::store_wr_t        wr,
	input  logic                      rd_en,
	input  logic [csd_pkg::AddrW-1:0] rd_addr,
	output logic [7:0]                rd_data
);

	logic [7:0] mem [csd_pkg::BufferBytes];

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= wr.data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

endmodule

### hw/rtl/csd_core.sv
module csd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                op,
	input  logic [7:0]          data_byte,
	output csd_pkg::result_t    res,
	output csd_pkg::store_wr_t  wr
);

	csd_pkg::phase_t             phase_q, b_phase, n_phase;
	csd_pkg::var_t               type_q, b_type, n_type;
	csd_pkg::var_t               len_q, b_len, n_len;
	csd_pkg::var_t               pc_q, b_pc, n_pc;
	logic [csd_pkg::VblW-1:0]    vbl_q, b_vbl, n_vbl, vbl_nx;
	logic [csd_pkg::HcW-1:0]     hc_q, b_hc, n_hc;
	logic                        sf_q, b_sf, n_sf;
	logic                        cf_q, n_cf;
	logic                        err_q, n_err;
	csd_pkg::var_t               acc, acc_nx, pc_inc;
	logic                        vdone, hdr_done;

	// a feed beat after completion starts from a clean header
	always_comb begin
		if (cf_q) begin
			b_phase = csd_pkg::PhType;
			b_type  = '0;
			b_len   = '0;
			b_pc    = '0;
			b_vbl   = '0;
			b_hc    = '0;
			b_sf    = 1'b0;
		end else begin
			b_phase = phase_q;
			b_type  = type_q;
			b_len   = len_q;
			b_pc    = pc_q;
			b_vbl   = vbl_q;
			b_hc    = hc_q;
			b_sf    = sf_q;
		end
	end

	// varint accumulate
	always_comb begin
		acc = (b_phase == csd_pkg::PhLen) ? b_len : b_type;
		if (b_vbl == '0) begin
			acc_nx = csd_pkg::VarW'(data_byte[5:0]);
			vbl_nx = csd_pkg::VblW'((4'd1 << data_byte[7:6]) - 4'd1);
		end else begin
			acc_nx = {acc[csd_pkg::VarW-9:0], data_byte};
			vbl_nx = b_vbl - 1'b1;
		end
		vdone  = (vbl_nx == '0);
		pc_inc = b_pc + 1'b1;
	end

	always_comb begin
		n_phase = phase_q;
		n_type  = type_q;
		n_len   = len_q;
		n_pc    = pc_q;
		n_vbl   = vbl_q;
		n_hc    = hc_q;
		n_sf    = sf_q;
		n_cf    = cf_q;
		n_err   = err_q;
		res.status = csd_pkg::StMore;
		res.kind   = csd_pkg::KindHdr;
		res.pbyte  = '0;
		wr.en   = 1'b0;
		wr.addr = b_pc[csd_pkg::AddrW-1:0];
		wr.data = data_byte;
		if (op) begin
			res.status = csd_pkg::StRead;
			res.kind   = csd_pkg::KindRej;
		end else if (err_q) begin
			res.status = csd_pkg::StErr;
			res.kind   = csd_pkg::KindRej;
		end else begin
			n_phase = b_phase;
			n_type  = b_type;
			n_len   = b_len;
			n_pc    = b_pc;
			n_vbl   = vbl_nx;
			n_hc    = b_hc;
			n_sf    = b_sf;
			n_cf    = 1'b0;
			if (b_phase != csd_pkg::PhPay) begin
				n_hc = b_hc + 1'b1;
				if (b_phase == csd_pkg::PhLen) begin
					n_len = acc_nx;
					if (vdone) begin
						n_sf    = ~csd_pkg::is_buffered(b_type);
						n_phase = csd_pkg::PhPay;
						if (csd_pkg::is_buffered(b_type) &&
						    acc_nx > csd_pkg::VarW'(csd_pkg::BufferBytes)) begin
							n_err      = 1'b1;
							res.status = csd_pkg::StErr;
							res.kind   = csd_pkg::KindRej;
						end else if (acc_nx == '0) begin
							n_cf       = 1'b1;
							res.status = csd_pkg::StDone;
						end
					end
				end else begin
					n_type  = acc_nx;
					n_phase = vdone ? csd_pkg::PhLen : csd_pkg::PhType;
				end
				if (!n_err && n_phase != csd_pkg::PhPay &&
				    n_hc >= csd_pkg::HcW'(csd_pkg::HdrBytes)) begin
					n_err      = 1'b1;
					res.status = csd_pkg::StErr;
					res.kind   = csd_pkg::KindRej;
				end
			end else begin
				n_vbl    = b_vbl;
				res.kind = csd_pkg::KindPay;
				if (b_sf) begin
					res.pbyte = data_byte;
				end else begin
					wr.en = (b_pc < csd_pkg::VarW'(csd_pkg::BufferBytes));
				end
				n_pc = pc_inc;
				if (pc_inc >= b_len) begin
					n_cf       = 1'b1;
					res.status = csd_pkg::StDone;
				end
			end
		end
		hdr_done     = (n_phase == csd_pkg::PhPay) || n_cf;
		res.ctype    = hdr_done ? n_type : '0;
		res.plen     = hdr_done ? n_len : '0;
		res.streamed = hdr_done & n_sf;
		wr.en        = wr.en & step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csd_pkg::PhType;
			type_q  <= '0;
			len_q   <= '0;
			pc_q    <= '0;
			vbl_q   <= '0;
			hc_q    <= '0;
			sf_q    <= 1'b0;
			cf_q    <= 1'b0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			type_q  <= n_type;
			len_q   <= n_len;
			pc_q    <= n_pc;
			vbl_q   <= n_vbl;
			hc_q    <= n_hc;
			sf_q    <= n_sf;
			cf_q    <= n_cf;
			err_q   <= n_err;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag dropped");

	a_hc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q <= csd_pkg::HcW'(csd_pkg::HdrBytes))
		else $error("header count overran");

	a_done_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		cf_q |-> phase_q == csd_pkg::PhPay)
		else $error("complete outside payload phase");

endmodule

### hw/rtl/capsule_stream_deframer.sv
// an accepted input beat is held in the input register, and its result in the result register on the master side
// throughput: one beat per cycle while the master side is not stalled; the next decode state is combinational
// a stalled master side holds the result register, and the input register fills behind it
// reset (arst_n low) clears the decode state, the sticky error and both valid flags
// the payload store is not cleared; its entries hold garbage until a payload writes them
module capsule_stream_deframer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [15:0]    s_tdata,   // data_byte, read_index
	input  logic           s_tuser,   // opcode
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [135:0]   m_tdata,   // capsule_type, payload_length, streamed, payload_byte, pad
	output logic [3:0]     m_tuser    // status, byte_kind
);

	logic                       v_s1, op_s1;
	logic [7:0]                 byte_s1, ridx_s1;
	logic                       out_v_q, rd_q, rok_q;
	csd_pkg::result_t           res, res_q;
	csd_pkg::store_wr_t         wr;
	logic                       adv, step, rd_en, rd_ok;
	logic [7:0]                 rd_data;

	assign adv      = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign step     = v_s1 && adv;
	assign rd_en    = step && op_s1;
	assign rd_ok    = 32'(ridx_s1) < 32'(csd_pkg::BufferBytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			ridx_s1 <= s_tdata[15:8];
		end
	end

	csd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.op        (op_s1),
		.data_byte (byte_s1),
		.res       (res),
		.wr        (wr)
	);

	csd_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (csd_pkg::AddrW'(ridx_s1)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
			rd_q  <= op_s1;
			rok_q <= rd_ok;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = {res_q.kind, res_q.status};
	assign m_tdata  = {3'b000,
		(rd_q ? (rok_q ? rd_data : 8'h00) : res_q.pbyte),
		res_q.streamed, res_q.plen, res_q.ctype};

endmodule
